/* design/abf_pkg.sv */
// ----------------------------------------------------------------------------
// abf_pkg
// Shared types, register indexes, event codes and reset values for the
// ACARS block framer.
// ----------------------------------------------------------------------------
package abf_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_MAX_PARITY_ERRORS     = 3'd0;
    localparam logic [2:0] REG_SYNC_BYTE             = 3'd1;
    localparam logic [2:0] REG_START_BYTE            = 3'd2;
    localparam logic [2:0] REG_END_TEXT_BYTE         = 3'd3;
    localparam logic [2:0] REG_END_BLOCK_BYTE        = 3'd4;
    localparam logic [2:0] REG_ESCAPE_BYTE           = 3'd5;
    localparam logic [2:0] REG_MAX_BLOCK_LENGTH      = 3'd6;
    localparam logic [2:0] REG_MIN_LENGTH_FOR_ESCAPE = 3'd7;

    // Reset values of the configuration registers
    localparam logic [3:0] RST_MAX_PARITY_ERRORS     = 4'd3;
    localparam logic [7:0] RST_SYNC_BYTE             = 8'd22;
    localparam logic [7:0] RST_START_BYTE            = 8'd1;
    localparam logic [7:0] RST_END_TEXT_BYTE         = 8'd131;
    localparam logic [7:0] RST_END_BLOCK_BYTE        = 8'd151;
    localparam logic [7:0] RST_ESCAPE_BYTE           = 8'd127;
    localparam logic [7:0] RST_MAX_BLOCK_LENGTH      = 8'd240;
    localparam logic [7:0] RST_MIN_LENGTH_FOR_ESCAPE = 8'd20;

    // Event codes on the result channel
    localparam logic [2:0] EV_NONE         = 3'd0;
    localparam logic [2:0] EV_SYNC_SEEN    = 3'd1;
    localparam logic [2:0] EV_BLOCK_START  = 3'd2;
    localparam logic [2:0] EV_TEXT_BYTE    = 3'd3;
    localparam logic [2:0] EV_BLOCK_END    = 3'd4;
    localparam logic [2:0] EV_PARITY_ABORT = 3'd5;
    localparam logic [2:0] EV_LENGTH_ABORT = 3'd6;
    localparam logic [2:0] EV_SYNC_LOST    = 3'd7;

    // Bit counter reload values after a byte decision
    localparam logic [3:0] BITS_HUNT = 4'd1;
    localparam logic [3:0] BITS_BYTE = 4'd8;

    // Saturation limit of the parity error counter
    localparam logic [4:0] PERR_MAX = 5'd31;

    typedef struct packed {
        logic [3:0] max_parity_errors;
        logic [7:0] sync_byte;
        logic [7:0] start_byte;
        logic [7:0] end_text_byte;
        logic [7:0] end_block_byte;
        logic [7:0] escape_byte;
        logic [7:0] max_block_length;
        logic [7:0] min_length_for_escape;
    } t_cfg;

    // Per-transfer result of the framer
    typedef struct packed {
        logic [2:0] event_res;
        logic [7:0] data_byte;
        logic       parity_ok;
        logic [7:0] block_length;
        logic [7:0] crc_first;
        logic [7:0] crc_second;
        logic       pll_reset;
        logic       polarity_inverted;
    } t_result;

    // Shifter status towards the framer
    typedef struct packed {
        logic       decode;
        logic [7:0] byte_val;
    } t_shift_stat;

endpackage

/* design/acars_block_framer.sv */
// ----------------------------------------------------------------------------
// acars_block_framer
// ACARS block framer: bit-level sync hunt, block framing, text streaming.
// ----------------------------------------------------------------------------
// One demodulated bit is taken per clock cycle while the input is not stalled,
// and each bit gives exactly one result, available in the output register in
// the cycle after its transfer. The sustained rate is one bit per cycle while
// no stall occurs; it is set by the update of the framing state, bit counter
// and shift register, which all update together on each accepted bit. The
// input is stalled only while a held result is itself stalled downstream.
// Configuration is written through a plain write port and takes effect on the next bit.
module acars_block_framer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // bit input channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_bit_in,
    // result channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_event_res,
    output logic [7:0] o_data_byte,
    output logic       o_parity_ok,
    output logic [7:0] o_block_length,
    output logic [7:0] o_crc_first,
    output logic [7:0] o_crc_second,
    output logic       o_pll_reset,
    output logic       o_polarity_inverted,
    // configuration write port
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    abf_pkg::t_cfg        cfg;
    abf_pkg::t_shift_stat stat;
    abf_pkg::t_result     n_result;
    abf_pkg::t_result     r_result;
    logic                 r_out_valid;
    logic                 accept;
    logic                 invert;
    logic [3:0]           reload;

    // Take a bit whenever the result register is free or being emptied
    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    abf_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    abf_shifter u_shifter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_bit    (i_bit_in),
        .i_invert (invert),
        .i_reload (reload),
        .o_stat   (stat)
    );

    abf_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_cfg    (cfg),
        .i_stat   (stat),
        .o_invert (invert),
        .o_reload (reload),
        .o_result (n_result)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_event_res         = r_result.event_res;
    assign o_data_byte         = r_result.data_byte;
    assign o_parity_ok         = r_result.parity_ok;
    assign o_block_length      = r_result.block_length;
    assign o_crc_first         = r_result.crc_first;
    assign o_crc_second        = r_result.crc_second;
    assign o_pll_reset         = r_result.pll_reset;
    assign o_polarity_inverted = r_result.polarity_inverted;

    // Every bit transfer leaves a result waiting
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_valid)
        else $error("accepted bit produced no result");

    // Aborts and lost sync always request a PLL reset
    a_abort_pll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_event_res == abf_pkg::EV_PARITY_ABORT
                    || o_event_res == abf_pkg::EV_LENGTH_ABORT
                    || o_event_res == abf_pkg::EV_SYNC_LOST)
        |-> o_pll_reset)
        else $error("return to sync hunt without PLL reset");

    // Block fields are zero except at block end
    a_block_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_event_res != abf_pkg::EV_BLOCK_END)
        |-> (o_block_length == 8'd0) && (o_crc_first == 8'd0) && (o_crc_second == 8'd0))
        else $error("block fields set outside block end");

endmodule

/* design/abf_cfg.sv */
// ----------------------------------------------------------------------------
// abf_cfg
// Configuration register file of the framer, plain write port.
// ----------------------------------------------------------------------------
module abf_cfg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_index,
    input  logic [7:0]     i_cfg_data,
    output abf_pkg::t_cfg  o_cfg
);

    abf_pkg::t_cfg r_cfg;

    // Register writes by index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_parity_errors     <= abf_pkg::RST_MAX_PARITY_ERRORS;
            r_cfg.sync_byte             <= abf_pkg::RST_SYNC_BYTE;
            r_cfg.start_byte            <= abf_pkg::RST_START_BYTE;
            r_cfg.end_text_byte         <= abf_pkg::RST_END_TEXT_BYTE;
            r_cfg.end_block_byte        <= abf_pkg::RST_END_BLOCK_BYTE;
            r_cfg.escape_byte           <= abf_pkg::RST_ESCAPE_BYTE;
            r_cfg.max_block_length      <= abf_pkg::RST_MAX_BLOCK_LENGTH;
            r_cfg.min_length_for_escape <= abf_pkg::RST_MIN_LENGTH_FOR_ESCAPE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                abf_pkg::REG_MAX_PARITY_ERRORS: begin
                    r_cfg.max_parity_errors <= i_cfg_data[3:0];
                end
                abf_pkg::REG_SYNC_BYTE:             r_cfg.sync_byte      <= i_cfg_data;
                abf_pkg::REG_START_BYTE:            r_cfg.start_byte     <= i_cfg_data;
                abf_pkg::REG_END_TEXT_BYTE:         r_cfg.end_text_byte  <= i_cfg_data;
                abf_pkg::REG_END_BLOCK_BYTE:        r_cfg.end_block_byte <= i_cfg_data;
                abf_pkg::REG_ESCAPE_BYTE:           r_cfg.escape_byte    <= i_cfg_data;
                abf_pkg::REG_MAX_BLOCK_LENGTH: begin
                    r_cfg.max_block_length <= i_cfg_data;
                end
                abf_pkg::REG_MIN_LENGTH_FOR_ESCAPE: begin
                    r_cfg.min_length_for_escape <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* design/abf_shifter.sv */
// ----------------------------------------------------------------------------
// abf_shifter
// Polarity correction, LSB-first byte assembly and bit counter.
// ----------------------------------------------------------------------------
module abf_shifter (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic                 i_bit,
    input  logic                 i_invert,
    input  logic [3:0]           i_reload,
    output abf_pkg::t_shift_stat o_stat
);

    logic [7:0] r_shift;
    logic [3:0] r_bits_left;
    logic [7:0] n_shift;
    logic       decode;

    // New bit enters at the top, byte decided when counter is 0 or 1
    assign n_shift = {i_bit ^ i_invert, r_shift[7:1]};
    assign decode  = (r_bits_left <= 4'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift     <= 8'd0;
            r_bits_left <= 4'd0;
        end else if (i_accept) begin
            r_shift <= n_shift;
            if (decode) begin
                r_bits_left <= i_reload;
            end else begin
                r_bits_left <= r_bits_left - 4'd1;
            end
        end
    end

    assign o_stat.decode   = decode;
    assign o_stat.byte_val = n_shift;

endmodule

/* design/abf_fsm.sv */
// ----------------------------------------------------------------------------
// abf_fsm
// Block framing state machine: sync hunt, header, text, CRC and end.
// ----------------------------------------------------------------------------
module abf_fsm (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  abf_pkg::t_cfg        i_cfg,
    input  abf_pkg::t_shift_stat i_stat,
    output logic                 o_invert,
    output logic [3:0]           o_reload,
    output abf_pkg::t_result     o_result
);

    typedef enum logic [6:0] {
        ST_HUNT = 7'b0000001,
        ST_SYN2 = 7'b0000010,
        ST_SOH  = 7'b0000100,
        ST_TXT  = 7'b0001000,
        ST_CRC1 = 7'b0010000,
        ST_CRC2 = 7'b0100000,
        ST_END  = 7'b1000000
    } t_state;

    t_state      r_state,  n_state;
    logic        r_invert, n_invert;
    logic [7:0]  r_text_count, n_text_count;
    logic [4:0]  r_perr, n_perr;
    logic [7:0]  r_crc_hold, n_crc_hold;
    logic [15:0] r_prev, n_prev;

    logic [7:0]  b;
    logic [7:0]  nsync;
    logic        pok;
    logic [8:0]  cnt;
    logic [8:0]  cnt_less3;
    logic [4:0]  perr_inc;
    logic [4:0]  perr_limit;

    assign b          = i_stat.byte_val;
    assign nsync      = ~i_cfg.sync_byte;
    assign pok        = ^b;
    assign cnt        = {1'b0, r_text_count} + 9'd1;
    assign cnt_less3  = (cnt >= 9'd3) ? (cnt - 9'd3) : 9'd0;
    assign perr_inc   = (r_perr < abf_pkg::PERR_MAX) ? (r_perr + 5'd1) : r_perr;
    assign perr_limit = {1'b0, i_cfg.max_parity_errors} + 5'd1;

    // Next state and result for one transfer
    always_comb begin
        n_state      = r_state;
        n_invert     = r_invert;
        n_text_count = r_text_count;
        n_perr       = r_perr;
        n_crc_hold   = r_crc_hold;
        n_prev       = r_prev;
        o_reload     = abf_pkg::BITS_BYTE;
        o_result     = '0;
        if (i_stat.decode) begin
            o_result.data_byte = b;
            o_result.parity_ok = pok;
            case (r_state)
                ST_SYN2: begin
                    if (b == i_cfg.sync_byte) begin
                        n_state = ST_SOH;
                        o_result.event_res = abf_pkg::EV_SYNC_SEEN;
                    end else if (b == nsync) begin
                        n_invert = ~r_invert;
                        o_result.event_res = abf_pkg::EV_SYNC_SEEN;
                    end else begin
                        n_state = ST_HUNT;
                        o_reload = abf_pkg::BITS_HUNT;
                        o_result.event_res = abf_pkg::EV_SYNC_LOST;
                        o_result.pll_reset = 1'b1;
                    end
                end
                ST_SOH: begin
                    if (b == i_cfg.start_byte) begin
                        n_state      = ST_TXT;
                        n_text_count = 8'd0;
                        n_perr       = 5'd0;
                        n_prev       = 16'd0;
                        o_result.event_res = abf_pkg::EV_BLOCK_START;
                    end else begin
                        n_state = ST_HUNT;
                        o_reload = abf_pkg::BITS_HUNT;
                        o_result.event_res = abf_pkg::EV_SYNC_LOST;
                        o_result.pll_reset = 1'b1;
                    end
                end
                ST_TXT: begin
                    // Stored count saturates at 255
                    n_text_count = cnt[8] ? 8'd255 : cnt[7:0];
                    if (!pok) begin
                        n_perr = perr_inc;
                    end
                    if (!pok && (perr_inc > perr_limit)) begin
                        n_state = ST_HUNT;
                        o_reload = abf_pkg::BITS_HUNT;
                        o_result.event_res = abf_pkg::EV_PARITY_ABORT;
                        o_result.pll_reset = 1'b1;
                    end else if (b == i_cfg.end_text_byte || b == i_cfg.end_block_byte) begin
                        n_prev  = {r_prev[7:0], b};
                        n_state = ST_CRC1;
                        o_result.event_res = abf_pkg::EV_TEXT_BYTE;
                    end else if ((cnt > {1'b0, i_cfg.min_length_for_escape})
                                 && (b == i_cfg.escape_byte)) begin
                        // Escape ends the block, last two text bytes are the CRC
                        n_text_count = cnt_less3[7:0];
                        n_state      = ST_END;
                        o_result.event_res    = abf_pkg::EV_BLOCK_END;
                        o_result.block_length = cnt_less3[7:0];
                        o_result.crc_first    = r_prev[15:8];
                        o_result.crc_second   = r_prev[7:0];
                    end else if (cnt > {1'b0, i_cfg.max_block_length}) begin
                        n_state = ST_HUNT;
                        o_reload = abf_pkg::BITS_HUNT;
                        o_result.event_res = abf_pkg::EV_LENGTH_ABORT;
                        o_result.pll_reset = 1'b1;
                    end else begin
                        n_prev = {r_prev[7:0], b};
                        o_result.event_res = abf_pkg::EV_TEXT_BYTE;
                    end
                end
                ST_CRC1: begin
                    n_crc_hold = b;
                    n_state    = ST_CRC2;
                end
                ST_CRC2: begin
                    n_state = ST_END;
                    o_result.event_res    = abf_pkg::EV_BLOCK_END;
                    o_result.block_length = r_text_count;
                    o_result.crc_first    = r_crc_hold;
                    o_result.crc_second   = b;
                end
                ST_END: begin
                    n_state = ST_HUNT;
                    o_result.pll_reset = 1'b1;
                end
                default: begin
                    // Sync hunt, bit by bit
                    if (b == i_cfg.sync_byte) begin
                        n_state = ST_SYN2;
                        o_result.event_res = abf_pkg::EV_SYNC_SEEN;
                    end else if (b == nsync) begin
                        n_invert = ~r_invert;
                        n_state  = ST_SYN2;
                        o_result.event_res = abf_pkg::EV_SYNC_SEEN;
                    end else begin
                        n_state  = ST_HUNT;
                        o_reload = abf_pkg::BITS_HUNT;
                        o_result.data_byte = 8'd0;
                        o_result.parity_ok = 1'b0;
                    end
                end
            endcase
        end
        o_result.polarity_inverted = n_invert;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_HUNT;
            r_invert     <= 1'b0;
            r_text_count <= 8'd0;
            r_perr       <= 5'd0;
            r_crc_hold   <= 8'd0;
            r_prev       <= 16'd0;
        end else if (i_accept) begin
            r_state      <= n_state;
            r_invert     <= n_invert;
            r_text_count <= n_text_count;
            r_perr       <= n_perr;
            r_crc_hold   <= n_crc_hold;
            r_prev       <= n_prev;
        end
    end

    assign o_invert = r_invert;

    // An abort always lands in sync hunt
    a_abort_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && (o_result.event_res == abf_pkg::EV_PARITY_ABORT
                     || o_result.event_res == abf_pkg::EV_LENGTH_ABORT)
        |=> r_state == ST_HUNT)
        else $error("abort did not return to sync hunt");

    // Polarity only flips on a sync event
    a_invert_on_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && (n_invert != r_invert)
        |-> o_result.event_res == abf_pkg::EV_SYNC_SEEN)
        else $error("polarity changed outside a sync event");

    // Text state is entered only from start of header
    a_txt_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == ST_TXT) |-> $past(r_state) == ST_SOH)
        else $error("text state entered without a start of header");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the ACARS block framer.
// Bits are fed serially with random gaps and the result channel is stalled at
// random. A bit-accurate predictor inside the bench tracks sync hunt, framing,
// polarity and text counting, and every result transfer is checked field by
// field against the oldest predicted result. Short directed blocks come
// first, then randomised frames under several register settings.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CYCLE_LIMIT = 1000000;

    localparam abf_pkg::t_cfg CFG_RESET = '{
        abf_pkg::RST_MAX_PARITY_ERRORS, abf_pkg::RST_SYNC_BYTE,
        abf_pkg::RST_START_BYTE, abf_pkg::RST_END_TEXT_BYTE,
        abf_pkg::RST_END_BLOCK_BYTE, abf_pkg::RST_ESCAPE_BYTE,
        abf_pkg::RST_MAX_BLOCK_LENGTH, abf_pkg::RST_MIN_LENGTH_FOR_ESCAPE
    };

    // How a random frame is closed
    localparam int END_ETX   = 0;
    localparam int END_ETB   = 1;
    localparam int END_ESC   = 2;
    localparam int END_LIMIT = 3;

    // Framing states of the predictor
    typedef enum logic [6:0] {
        FR_HUNT = 7'b0000001,
        FR_SYN2 = 7'b0000010,
        FR_SOH  = 7'b0000100,
        FR_TXT  = 7'b0001000,
        FR_CRC1 = 7'b0010000,
        FR_CRC2 = 7'b0100000,
        FR_END  = 7'b1000000
    } t_frame_state;

    // DUT ports
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic       o_stall;
    logic       i_bit_in    = 1'b0;
    logic       o_valid;
    logic       i_stall     = 1'b0;
    logic [2:0] o_event_res;
    logic [7:0] o_data_byte;
    logic       o_parity_ok;
    logic [7:0] o_block_length;
    logic [7:0] o_crc_first;
    logic [7:0] o_crc_second;
    logic       o_pll_reset;
    logic       o_polarity_inverted;
    logic       i_cfg_we    = 1'b0;
    logic [2:0] i_cfg_index = abf_pkg::REG_MAX_PARITY_ERRORS;
    logic [7:0] i_cfg_data  = 8'd0;

    // Predictor state and register copy
    abf_pkg::t_cfg cfg      = CFG_RESET;
    t_frame_state  fr_state = FR_HUNT;
    logic [7:0]    sh_byte  = 8'd0;
    logic [3:0]    bit_cnt  = 4'd0;
    logic          inv_flag = 1'b0;
    logic [7:0]    txt_cnt  = 8'd0;
    logic [4:0]    perr_cnt = 5'd0;
    logic [7:0]    crc_keep = 8'd0;
    logic [15:0]   last_two = 16'd0;

    // Results predicted but not yet seen on the output
    abf_pkg::t_result due_results[$];

    int unsigned mismatches  = 0;
    int unsigned cycle_count = 0;
    int unsigned bits_sent   = 0;
    int          stall_left  = 0;
    bit          tx_steady   = 1'b0;
    bit          rx_steady   = 1'b0;

    acars_block_framer i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_bit_in           (i_bit_in),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_event_res        (o_event_res),
        .o_data_byte        (o_data_byte),
        .o_parity_ok        (o_parity_ok),
        .o_block_length     (o_block_length),
        .o_crc_first        (o_crc_first),
        .o_crc_second       (o_crc_second),
        .o_pll_reset        (o_pll_reset),
        .o_polarity_inverted(o_polarity_inverted),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Advance the framer by one bit and return the result it gives
    function automatic abf_pkg::t_result frame_bit(input logic b);
        abf_pkg::t_result r;
        logic [7:0]       cur;
        logic             odd;
        int               cnt;
        int               n;
        r = '0;
        sh_byte = {b ^ inv_flag, sh_byte[7:1]};
        if (bit_cnt > 4'd1) begin
            bit_cnt = bit_cnt - 4'd1;
        end else begin
            cur = sh_byte;
            odd = ^cur;
            r.data_byte = cur;
            r.parity_ok = odd;
            case (fr_state)
                FR_SYN2: begin
                    if (cur == cfg.sync_byte) begin
                        fr_state = FR_SOH;
                        bit_cnt = abf_pkg::BITS_BYTE;
                        r.event_res = abf_pkg::EV_SYNC_SEEN;
                    end else if (cur == ~cfg.sync_byte) begin
                        inv_flag = ~inv_flag;
                        bit_cnt = abf_pkg::BITS_BYTE;
                        r.event_res = abf_pkg::EV_SYNC_SEEN;
                    end else begin
                        fr_state = FR_HUNT;
                        bit_cnt = abf_pkg::BITS_HUNT;
                        r.event_res = abf_pkg::EV_SYNC_LOST;
                        r.pll_reset = 1'b1;
                    end
                end
                FR_SOH: begin
                    if (cur == cfg.start_byte) begin
                        fr_state = FR_TXT;
                        txt_cnt = 8'd0;
                        perr_cnt = 5'd0;
                        last_two = 16'd0;
                        bit_cnt = abf_pkg::BITS_BYTE;
                        r.event_res = abf_pkg::EV_BLOCK_START;
                    end else begin
                        fr_state = FR_HUNT;
                        bit_cnt = abf_pkg::BITS_HUNT;
                        r.event_res = abf_pkg::EV_SYNC_LOST;
                        r.pll_reset = 1'b1;
                    end
                end
                FR_TXT: begin
                    cnt = int'(txt_cnt) + 1;
                    txt_cnt = (cnt > 255) ? 8'd255 : 8'(cnt);
                    if (!odd && perr_cnt < abf_pkg::PERR_MAX)
                        perr_cnt = perr_cnt + 5'd1;
                    if (!odd && int'(perr_cnt) > int'(cfg.max_parity_errors) + 1) begin
                        fr_state = FR_HUNT;
                        bit_cnt = abf_pkg::BITS_HUNT;
                        r.event_res = abf_pkg::EV_PARITY_ABORT;
                        r.pll_reset = 1'b1;
                    end else if (cur == cfg.end_text_byte || cur == cfg.end_block_byte) begin
                        last_two = {last_two[7:0], cur};
                        fr_state = FR_CRC1;
                        bit_cnt = abf_pkg::BITS_BYTE;
                        r.event_res = abf_pkg::EV_TEXT_BYTE;
                    end else if (cnt > int'(cfg.min_length_for_escape) &&
                                 cur == cfg.escape_byte) begin
                        // early end: the two bytes before the escape are the CRC
                        n = (cnt >= 3) ? cnt - 3 : 0;
                        if (n > 255) n = 255;
                        r.block_length = 8'(n);
                        r.crc_first = last_two[15:8];
                        r.crc_second = last_two[7:0];
                        txt_cnt = 8'(n);
                        fr_state = FR_END;
                        bit_cnt = abf_pkg::BITS_BYTE;
                        r.event_res = abf_pkg::EV_BLOCK_END;
                    end else if (cnt > int'(cfg.max_block_length)) begin
                        fr_state = FR_HUNT;
                        bit_cnt = abf_pkg::BITS_HUNT;
                        r.event_res = abf_pkg::EV_LENGTH_ABORT;
                        r.pll_reset = 1'b1;
                    end else begin
                        last_two = {last_two[7:0], cur};
                        bit_cnt = abf_pkg::BITS_BYTE;
                        r.event_res = abf_pkg::EV_TEXT_BYTE;
                    end
                end
                FR_CRC1: begin
                    crc_keep = cur;
                    fr_state = FR_CRC2;
                    bit_cnt = abf_pkg::BITS_BYTE;
                end
                FR_CRC2: begin
                    r.block_length = txt_cnt;
                    r.crc_first = crc_keep;
                    r.crc_second = cur;
                    fr_state = FR_END;
                    bit_cnt = abf_pkg::BITS_BYTE;
                    r.event_res = abf_pkg::EV_BLOCK_END;
                end
                FR_END: begin
                    fr_state = FR_HUNT;
                    bit_cnt = abf_pkg::BITS_BYTE;
                    r.pll_reset = 1'b1;
                end
                default: begin
                    if (cur == cfg.sync_byte) begin
                        fr_state = FR_SYN2;
                        bit_cnt = abf_pkg::BITS_BYTE;
                        r.event_res = abf_pkg::EV_SYNC_SEEN;
                    end else if (cur == ~cfg.sync_byte) begin
                        inv_flag = ~inv_flag;
                        fr_state = FR_SYN2;
                        bit_cnt = abf_pkg::BITS_BYTE;
                        r.event_res = abf_pkg::EV_SYNC_SEEN;
                    end else begin
                        fr_state = FR_HUNT;
                        bit_cnt = abf_pkg::BITS_HUNT;
                        r.data_byte = 8'd0;
                        r.parity_ok = 1'b0;
                    end
                end
            endcase
        end
        r.polarity_inverted = inv_flag;
        return r;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
            note_mismatch($sformatf("%s expected %0d got %0d", name, want, got));
    endtask

    // Result checking and random stall of the result channel
    always @(posedge i_clk) begin
        abf_pkg::t_result got;
        abf_pkg::t_result want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                got = '{o_event_res, o_data_byte, o_parity_ok, o_block_length,
                        o_crc_first, o_crc_second, o_pll_reset, o_polarity_inverted};
                if (due_results.size() == 0) begin
                    note_mismatch("result transfer with no bit outstanding");
                end else begin
                    want = due_results.pop_front();
                    check_field("event_res", want.event_res, got.event_res);
                    check_field("data_byte", want.data_byte, got.data_byte);
                    check_field("parity_ok", want.parity_ok, got.parity_ok);
                    check_field("block_length", want.block_length, got.block_length);
                    check_field("crc_first", want.crc_first, got.crc_first);
                    check_field("crc_second", want.crc_second, got.crc_second);
                    check_field("pll_reset", want.pll_reset, got.pll_reset);
                    check_field("polarity_inverted", want.polarity_inverted,
                                got.polarity_inverted);
                end
                stall_left = rx_steady ? 0 : $urandom_range(0, 6);
                if ($urandom_range(0, 99) == 0) rx_steady = !rx_steady;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // One bit transfer; valid is left high for a back-to-back follow-up
    task automatic send_bit(input logic b);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 6);
        if ($urandom_range(0, 99) == 0) tx_steady = !tx_steady;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_bit_in <= b;
        do @(posedge i_clk); while (o_stall);
        due_results.push_back(frame_bit(b));
        bits_sent++;
    endtask

    // Byte sent LSB first, pre-compensated for the current polarity
    task automatic send_byte(input logic [7:0] v);
        for (int i = 0; i < 8; i++)
            send_bit(v[i] ^ inv_flag);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
    endtask

    task automatic apply_config(input abf_pkg::t_cfg c);
        drain_results();
        write_reg(abf_pkg::REG_MAX_PARITY_ERRORS, {4'd0, c.max_parity_errors});
        write_reg(abf_pkg::REG_SYNC_BYTE, c.sync_byte);
        write_reg(abf_pkg::REG_START_BYTE, c.start_byte);
        write_reg(abf_pkg::REG_END_TEXT_BYTE, c.end_text_byte);
        write_reg(abf_pkg::REG_END_BLOCK_BYTE, c.end_block_byte);
        write_reg(abf_pkg::REG_ESCAPE_BYTE, c.escape_byte);
        write_reg(abf_pkg::REG_MAX_BLOCK_LENGTH, c.max_block_length);
        write_reg(abf_pkg::REG_MIN_LENGTH_FOR_ESCAPE, c.min_length_for_escape);
        i_cfg_we <= 1'b0;
        cfg = c;
    endtask

    // Repeat the sync pattern bit by bit until the hunt locks on
    task automatic acquire_sync(input logic inverted);
        logic [7:0] pat;
        pat = inverted ? ~cfg.sync_byte : cfg.sync_byte;
        for (int k = 0; k < 80 && fr_state == FR_HUNT; k++)
            send_bit(pat[k % 8] ^ inv_flag);
    endtask

    task automatic open_block(input logic inverted, input int toggles);
        acquire_sync(inverted);
        if (fr_state == FR_SYN2) begin
            repeat (toggles) send_byte(~cfg.sync_byte);
            send_byte(cfg.sync_byte);
            send_byte(cfg.start_byte);
        end
    endtask

    // Text byte that is no terminator; bad parity with the given percentage
    function automatic logic [7:0] pick_text(input int perr_pct);
        logic [7:0] v;
        v = 8'd0;
        for (int k = 0; k < 16; k++) begin
            v = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 99) >= perr_pct && !(^v)) v[0] = ~v[0];
            if (v != cfg.end_text_byte && v != cfg.end_block_byte && v != cfg.escape_byte)
                break;
        end
        return v;
    endfunction

    function automatic logic [7:0] other_than(input logic [7:0] v);
        logic [7:0] w;
        w = 8'($urandom_range(0, 255));
        if (w == v || w == ~v) w = w ^ 8'h01;
        return w;
    endfunction

    // ending: ETX, ETB, escape, or run into the length limit
    task automatic run_frame(input int text_len, input int ending, input int perr_pct);
        logic [7:0] v;
        repeat ($urandom_range(0, 12)) send_bit(1'($urandom_range(0, 1)));
        acquire_sync(1'($urandom_range(0, 1)));
        if (fr_state != FR_SYN2) return;
        if ($urandom_range(0, 3) == 0) send_byte(~cfg.sync_byte);
        if ($urandom_range(0, 11) == 0) send_byte(other_than(cfg.sync_byte));
        else send_byte(cfg.sync_byte);
        if (fr_state == FR_SOH) begin
            if ($urandom_range(0, 11) == 0) send_byte(other_than(cfg.start_byte));
            else send_byte(cfg.start_byte);
        end
        for (int k = 0; k < text_len && fr_state == FR_TXT; k++) begin
            send_byte(pick_text(perr_pct));
            // occasional hold-off mid-block until the output has caught up
            if ($urandom_range(0, 199) == 0) drain_results();
        end
        if (fr_state == FR_TXT) begin
            case (ending)
                END_ETX: send_byte(cfg.end_text_byte);
                END_ETB: send_byte(cfg.end_block_byte);
                END_ESC: send_byte(cfg.escape_byte);
                default: ;
            endcase
        end
        // CRC bytes, closing byte, or filler text up to the length limit
        for (int k = 0; k < 300 && fr_state != FR_HUNT; k++) begin
            v = (fr_state == FR_TXT) ? pick_text(0) : 8'($urandom_range(0, 255));
            send_byte(v);
        end
    endtask

    task automatic run_frames(input int budget);
        int unsigned first;
        int          cap;
        int          ending;
        first = bits_sent;
        while (bits_sent - first < budget) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(8, 40)) send_bit(1'($urandom_range(0, 1)));
            end else begin
                cap = int'(cfg.max_block_length) + 2;
                if (cap > 30) cap = 30;
                ending = $urandom_range(END_ETX, END_LIMIT);
                if (ending == END_LIMIT && cfg.max_block_length > 40) ending = END_ETX;
                run_frame($urandom_range(0, cap), ending, $urandom_range(0, 15));
            end
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Noise in sync hunt straight out of reset
    task automatic test_idle_hunt();
        repeat (10) send_bit(1'b0);
        repeat (10) send_bit(1'b1);
        repeat (12) send_bit(1'($urandom_range(0, 1)));
        drain_results();
    endtask

    // Block closed by ETX with extreme text and CRC values
    task automatic test_plain_block();
        open_block(1'b0, 0);
        send_byte(8'h80);
        send_byte(8'hFE);
        send_byte(8'h01);
        send_byte(cfg.escape_byte);   // too short for an early end
        send_byte(8'h00);             // parity error
        send_byte(cfg.end_text_byte);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h55);
        drain_results();
    endtask

    // Inverted sync in the hunt and again in second sync, ETB then ETX endings
    task automatic test_polarity_flip();
        open_block(1'b1, 1);
        send_byte(8'h70);
        send_byte(8'h0D);
        send_byte(cfg.end_block_byte);
        send_byte(8'hA5);
        send_byte(8'h5A);
        send_byte(8'h00);
        open_block(1'b1, 2);
        send_byte(cfg.end_text_byte);
        repeat (3) send_byte(8'($urandom_range(0, 255)));
        drain_results();
    endtask

    // Wrong byte in second sync, then wrong start of header
    task automatic test_sync_lost();
        acquire_sync(1'b0);
        send_byte(other_than(cfg.sync_byte));
        acquire_sync(1'b0);
        send_byte(cfg.sync_byte);
        send_byte(other_than(cfg.start_byte));
        drain_results();
    endtask

    task automatic test_parity_abort();
        open_block(1'b0, 0);
        repeat (6) send_byte(8'h03);
        drain_results();
    endtask

    // Escape after more than the minimum length ends the block early
    task automatic test_escape_end();
        open_block(1'b0, 0);
        repeat (int'(cfg.min_length_for_escape) + 2) send_byte(pick_text(0));
        send_byte(cfg.escape_byte);
        send_byte(8'hC3);
        drain_results();
    endtask

    task automatic test_length_abort();
        abf_pkg::t_cfg c;
        c = cfg;
        c.max_block_length = 8'd3;
        apply_config(c);
        open_block(1'b0, 0);
        repeat (5) send_byte(pick_text(0));
        drain_results();
    endtask

    task automatic test_random_frames();
        abf_pkg::t_cfg c;
        // tight limits: single byte blocks, escape at any length
        apply_config('{4'd0, 8'h00, 8'hFF, 8'h01, 8'hFE, 8'h00, 8'd1, 8'd0});
        run_frames(200);
        repeat (2) begin
            c.max_parity_errors     = 4'($urandom_range(0, 15));
            c.sync_byte             = 8'($urandom_range(0, 255));
            c.start_byte            = 8'($urandom_range(0, 255));
            c.end_text_byte         = 8'($urandom_range(0, 255));
            c.end_block_byte        = 8'($urandom_range(0, 255));
            c.escape_byte           = 8'($urandom_range(0, 255));
            c.max_block_length      = 8'($urandom_range(1, 40));
            c.min_length_for_escape = 8'($urandom_range(0, 30));
            apply_config(c);
            run_frames(200);
        end
        apply_config(CFG_RESET);
        run_frames(200);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_idle_hunt();
        test_plain_block();
        test_polarity_flip();
        test_sync_lost();
        test_parity_abort();
        test_escape_end();
        test_length_abort();
        test_random_frames();
        drain_results();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0 && due_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
